// ===== sv/websocket_frame_decoder_defines.svh =====
// assertion macros of the websocket frame decoder checker
`ifndef WEBSOCKET_FRAME_DECODER_DEFINES_SVH
`define WEBSOCKET_FRAME_DECODER_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define WSFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define WSFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/wsfd_pkg.sv =====
// types and constants of the websocket frame decoder
`default_nettype none

package wsfd_pkg;

	// parser phases
	typedef enum logic [2:0] {
		PH_HDR0    = 3'd0,
		PH_HDR1    = 3'd1,
		PH_EXT16   = 3'd2,
		PH_EXT64   = 3'd3,
		PH_KEY     = 3'd4,
		PH_PAYLOAD = 3'd5
	} wsfd_phase_t;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_EMPTY   = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_LEN16 = 2'd1;
	localparam logic [1:0] ERR_LEN64 = 2'd2;
	localparam logic [1:0] ERR_MAX   = 2'd3;

	localparam int unsigned MAX_LEN_W = 63;
	localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 63'd52428800;

	// length codes of the second header byte
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	// one classified result waiting for the back end
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [7:0] key;
		logic [3:0] opcode;
		logic       fin;
		logic       last;
		logic [1:0] err;
	} wsfd_entry_t;

endpackage

`default_nettype wire

// ===== sv/wsfd_front.sv =====
// header parser: classifies each received byte and queues result requests
`default_nettype none

module wsfd_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic [7:0]                      in_byte,
	input  wire logic                            cfg_we,
	input  wire logic [wsfd_pkg::MAX_LEN_W-1:0]  cfg_wdata,
	output logic                                 push,
	output wsfd_pkg::wsfd_entry_t                push_entry
);

	wsfd_pkg::wsfd_phase_t phase_q, phase_d;
	logic [2:0]  cnt_q;
	logic        halted_q;
	logic [4:0]  fin_op_q;
	logic        mask_q;
	logic [1:0]  idx_q;
	logic [wsfd_pkg::MAX_LEN_W-1:0] max_q;
	logic [63:0] acc_q;
	logic [31:0] key_q;
	logic [63:0] rem_q;

	logic        take;
	logic [6:0]  len7;
	logic [15:0] acc16_nx;
	logic [63:0] acc64_nx;
	logic [63:0] len_sel;
	logic        over_max;
	logic        bad16, bad64;
	logic        len_done;
	logic        mask_nx;
	logic [1:0]  fail_code;
	logic        fail;
	logic        key_end;
	logic        start_pay;
	logic [63:0] start_len;
	logic        empty;
	logic        pay;
	logic        pay_last;
	logic [7:0]  key_byte;

	assign take     = in_valid & ~halted_q;
	assign len7     = in_byte[6:0];
	assign acc16_nx = {acc_q[7:0], in_byte};
	assign acc64_nx = {acc_q[55:0], in_byte};

	always_comb begin
		case (phase_q)
			wsfd_pkg::PH_HDR1:  len_sel = {57'd0, len7};
			wsfd_pkg::PH_EXT16: len_sel = {48'd0, acc16_nx};
			default:            len_sel = acc64_nx;
		endcase
	end

	assign over_max = len_sel > {1'b0, max_q};
	assign bad16    = acc16_nx < 16'd126;
	assign bad64    = (acc64_nx[63:16] == 48'd0) | acc64_nx[63];
	assign mask_nx  = (phase_q == wsfd_pkg::PH_HDR1) ? in_byte[7] : mask_q;
	assign key_end  = take & (phase_q == wsfd_pkg::PH_KEY) & (cnt_q == 3'd3);

	// complete length in hand and well formed
	assign len_done = take & (
		((phase_q == wsfd_pkg::PH_HDR1) & (len7 < wsfd_pkg::LEN7_EXT16)) |
		((phase_q == wsfd_pkg::PH_EXT16) & (cnt_q == 3'd1) & ~bad16) |
		((phase_q == wsfd_pkg::PH_EXT64) & (cnt_q == 3'd7) & ~bad64));

	always_comb begin
		fail_code = wsfd_pkg::ERR_NONE;
		if (take && phase_q == wsfd_pkg::PH_EXT16 && cnt_q == 3'd1 && bad16) begin
			fail_code = wsfd_pkg::ERR_LEN16;
		end else if (take && phase_q == wsfd_pkg::PH_EXT64 && cnt_q == 3'd7 && bad64) begin
			fail_code = wsfd_pkg::ERR_LEN64;
		end else if (len_done && over_max) begin
			fail_code = wsfd_pkg::ERR_MAX;
		end
	end

	assign fail      = fail_code != wsfd_pkg::ERR_NONE;
	assign start_pay = (len_done & ~over_max & ~mask_nx) | key_end;
	assign start_len = (phase_q == wsfd_pkg::PH_KEY) ? acc_q : len_sel;
	assign empty     = start_pay & (start_len == 64'd0);
	assign pay       = take & (phase_q == wsfd_pkg::PH_PAYLOAD);
	assign pay_last  = rem_q == 64'd1;

	always_comb begin
		case (idx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (take) begin
			case (phase_q)
				wsfd_pkg::PH_HDR1: begin
					if (len7 == wsfd_pkg::LEN7_EXT16) begin
						phase_d = wsfd_pkg::PH_EXT16;
					end else if (len7 == wsfd_pkg::LEN7_EXT64) begin
						phase_d = wsfd_pkg::PH_EXT64;
					end
				end
				wsfd_pkg::PH_EXT16, wsfd_pkg::PH_EXT64, wsfd_pkg::PH_KEY: begin
					phase_d = phase_q;
				end
				wsfd_pkg::PH_PAYLOAD: begin
					if (pay_last) begin
						phase_d = wsfd_pkg::PH_HDR0;
					end
				end
				default: phase_d = wsfd_pkg::PH_HDR1;
			endcase
			if (fail) begin
				phase_d = wsfd_pkg::PH_HDR0;
			end else if (len_done && mask_nx) begin
				phase_d = wsfd_pkg::PH_KEY;
			end else if (start_pay) begin
				phase_d = empty ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_PAYLOAD;
			end
		end
	end

	// result request
	always_comb begin
		push              = fail | empty | pay;
		push_entry.kind   = fail ? wsfd_pkg::KIND_ERROR :
		                    (pay ? wsfd_pkg::KIND_PAYLOAD : wsfd_pkg::KIND_EMPTY);
		push_entry.data   = pay ? in_byte : 8'd0;
		push_entry.key    = (pay & mask_q) ? key_byte : 8'd0;
		push_entry.opcode = fin_op_q[3:0];
		push_entry.fin    = fin_op_q[4];
		push_entry.last   = pay ? pay_last : 1'b1;
		push_entry.err    = fail_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= wsfd_pkg::PH_HDR0;
			cnt_q    <= 3'd0;
			halted_q <= 1'b0;
			fin_op_q <= 5'd0;
			mask_q   <= 1'b0;
			idx_q    <= 2'd0;
			max_q    <= wsfd_pkg::MAX_LEN_RESET;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			phase_q <= phase_d;
			if (fail) begin
				halted_q <= 1'b1;
			end
			if (take) begin
				case (phase_q)
					wsfd_pkg::PH_HDR1: begin
						mask_q <= in_byte[7];
						cnt_q  <= 3'd0;
					end
					wsfd_pkg::PH_EXT16, wsfd_pkg::PH_EXT64, wsfd_pkg::PH_KEY: begin
						// counter restarts once the length or the key is complete
						cnt_q <= (len_done || key_end) ? 3'd0 : cnt_q + 3'd1;
					end
					wsfd_pkg::PH_PAYLOAD: begin
						idx_q <= idx_q + 2'd1;
					end
					default: fin_op_q <= {in_byte[7], in_byte[3:0]};
				endcase
				if (start_pay) begin
					idx_q <= 2'd0;
				end
			end
		end
	end

	// datapath registers, always written before use
	always_ff @(posedge clk) begin
		if (take) begin
			case (phase_q)
				wsfd_pkg::PH_HDR1:    acc_q <= (len7 >= wsfd_pkg::LEN7_EXT16) ? 64'd0 : len_sel;
				wsfd_pkg::PH_EXT16:   acc_q <= {48'd0, acc16_nx};
				wsfd_pkg::PH_EXT64:   acc_q <= acc64_nx;
				wsfd_pkg::PH_KEY:     key_q <= {key_q[23:0], in_byte};
				wsfd_pkg::PH_PAYLOAD: rem_q <= rem_q - 64'd1;
				default:              acc_q <= acc_q;
			endcase
			if (start_pay) begin
				rem_q <= start_len;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/wsfd_queue.sv =====
// short queue of result requests between parser and output stage
`default_nettype none

module wsfd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire wsfd_pkg::wsfd_entry_t push_entry,
	input  wire logic                  pop,
	output wsfd_pkg::wsfd_entry_t      head,
	output logic                       not_empty,
	output logic                       full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	wsfd_pkg::wsfd_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign full      = count_q == CNT_W'(DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/wsfd_back.sv =====
// output stage: unmasks payload and holds the result for the receiver
`default_nettype none

module wsfd_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  q_valid,
	input  wire wsfd_pkg::wsfd_entry_t q_head,
	output logic                       q_pop,
	output logic                       m_valid,
	input  wire logic                  m_ready,
	output logic [15:0]                m_data,
	output logic [1:0]                 m_user,
	output logic                       m_last
);

	logic        valid_q;
	logic [15:0] data_q;
	logic [1:0]  user_q;
	logic        last_q;

	assign q_pop   = q_valid & (~valid_q | m_ready);
	assign m_valid = valid_q;
	assign m_data  = data_q;
	assign m_user  = user_q;
	assign m_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (m_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_q <= {1'b0, q_head.err, q_head.fin, q_head.opcode, q_head.data ^ q_head.key};
			user_q <= q_head.kind;
			last_q <= q_head.last;
		end
	end

endmodule

`default_nettype wire

// ===== sv/websocket_frame_decoder.sv =====
// top level of the websocket frame decoder
//
// s_axis carries the received byte stream, one byte per request in tdata.
// m_axis gives one result per request: tuser is the kind (payload byte,
// empty frame done, error), tlast marks the final result of a frame, and
// tdata holds the unmasked byte, opcode, fin bit and error code.
// cfg_we / cfg_wdata write the maximum payload length, which the user must
// write only while idle; the block itself does not enforce this.
// throughput: one byte per cycle while the queue has room.
// each result passes through the queue, then the output register, to m_axis.
// header bytes give no result unless they fail a check or end an empty frame.
// reset clears the parser to await a frame start, empties the queue,
// drops any pending result and restores the maximum length to 50 MiB.
// when the receiver stalls the output register holds, the queue fills,
// and s_axis_tready falls once FIFO_DEPTH results are waiting.
// a length error is sticky: the block keeps taking bytes but stays silent
// until the next reset.
`default_nettype none

module websocket_frame_decoder #(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// received stream
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [7:0]                      s_axis_tdata,   // [7:0] data_byte
	// decoded results
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// [7:0] payload_byte, [11:8] frame_opcode, [12] final_fragment,
	// [14:13] error_code, [15] zero
	output logic [15:0]                          m_axis_tdata,
	output logic [1:0]                           m_axis_tuser,   // [1:0] result_kind
	output logic                                 m_axis_tlast,   // last_of_frame
	// maximum payload length register
	input  wire logic                            cfg_we,
	input  wire logic [wsfd_pkg::MAX_LEN_W-1:0]  cfg_wdata
);

	logic                  in_valid;
	logic                  push;
	wsfd_pkg::wsfd_entry_t push_entry;
	wsfd_pkg::wsfd_entry_t q_head;
	logic                  q_not_empty;
	logic                  q_full;
	logic                  q_pop;

	// take a byte whenever there is room for its possible result
	assign s_axis_tready = ~q_full;
	assign in_valid      = s_axis_tvalid & s_axis_tready;

	// front: frame header parsing and classification
	wsfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_byte    (s_axis_tdata),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.push       (push),
		.push_entry (push_entry)
	);

	// decouples parser from a stalled receiver
	wsfd_queue #(
		.DEPTH (FIFO_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.head       (q_head),
		.not_empty  (q_not_empty),
		.full       (q_full)
	);

	// back: unmask and present results
	wsfd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_not_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_data  (m_axis_tdata),
		.m_user  (m_axis_tuser),
		.m_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== sv/wsfd_checker.sv =====
// port-level checks of the websocket frame decoder and their binding
`default_nettype none

`include "websocket_frame_decoder_defines.svh"

module wsfd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);

	`WSFD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")
	`WSFD_ASSERT_NOW(a_payload_no_err, m_axis_tvalid && m_axis_tuser == wsfd_pkg::KIND_PAYLOAD, m_axis_tdata[14:13] == wsfd_pkg::ERR_NONE, "payload result carries an error code")
	`WSFD_ASSERT_NOW(a_marker_shape, m_axis_tvalid && m_axis_tuser != wsfd_pkg::KIND_PAYLOAD, m_axis_tlast && m_axis_tdata[7:0] == 8'd0, "marker result not last or has data")
	`WSFD_ASSERT_NOW(a_error_coded, m_axis_tvalid && m_axis_tuser == wsfd_pkg::KIND_ERROR, m_axis_tdata[14:13] != wsfd_pkg::ERR_NONE, "error result without a code")

endmodule

bind websocket_frame_decoder wsfd_checker u_wsfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== bench/tb.sv =====
// self-checking bench for the websocket frame decoder: tracks the stream, checks each result
`timescale 1ns / 100ps

module tb;
	import wsfd_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DUT_LATENCY  = 2;
	localparam logic [MAX_LEN_W-1:0] MAX_LEN_ALL = '1;

	// one decoded result as it leaves m_axis
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [3:0] opcode;
		logic       fin;
		logic       last;
		logic [1:0] err;
	} decoded_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;    // [7:0] data_byte
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	// [7:0] payload_byte, [11:8] frame_opcode, [12] final_fragment,
	// [14:13] error_code, [15] zero
	logic [15:0]          m_axis_tdata;
	logic [1:0]           m_axis_tuser;    // [1:0] result_kind
	logic                 m_axis_tlast;    // last_of_frame
	logic                 cfg_we;
	logic [MAX_LEN_W-1:0] cfg_wdata;

	// frame tracker: mirrors the parser and holds the results still owed
	wsfd_phase_t          rx_phase;
	logic [3:0]           rx_hdr_count;
	logic [4:0]           rx_fin_opcode;
	logic                 rx_masked;
	logic [63:0]          rx_length;
	logic [31:0]          rx_key;
	logic [63:0]          rx_left;
	logic [1:0]           rx_key_pos;
	logic                 rx_halted;
	logic [MAX_LEN_W-1:0] rx_max_length;
	decoded_result_t      expected_results[$];

	// idle pattern of both sides
	int send_gap_max = 9;
	int recv_gap_max = 9;
	int stall_cycles_left = 0;

	// run statistics
	int mismatches = 0;
	int results_checked = 0;
	int bytes_accepted = 0;
	int frames_sent = 0;
	int empty_frames = 0;
	int ext16_frames = 0;
	int ext64_frames = 0;
	int config_writes = 0;
	int input_stall_cycles = 0;
	int cycle_count = 0;
	logic [1:0] closing_error = ERR_NONE;

	websocket_frame_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------- tracker

	function automatic void owe_result(input logic [1:0] kind, input logic [7:0] value,
			input logic last, input logic [1:0] err);
		decoded_result_t r;
		r.kind   = kind;
		r.data   = value;
		r.opcode = rx_fin_opcode[3:0];
		r.fin    = rx_fin_opcode[4];
		r.last   = last;
		r.err    = err;
		expected_results.push_back(r);
	endfunction

	// errors are sticky: the parser goes silent until reset
	function automatic void halt_on_error(input logic [1:0] err);
		rx_halted = 1'b1;
		rx_phase  = PH_HDR0;
		owe_result(KIND_ERROR, 8'h00, 1'b1, err);
	endfunction

	function automatic void open_payload();
		rx_key_pos = 2'd0;
		if (rx_length == 64'd0) begin
			rx_phase = PH_HDR0;
			owe_result(KIND_EMPTY, 8'h00, 1'b1, ERR_NONE);
		end else begin
			rx_left  = rx_length;
			rx_phase = PH_PAYLOAD;
		end
	endfunction

	// limit check comes after the form checks of the extended lengths
	function automatic void close_length();
		if (rx_length > {1'b0, rx_max_length}) begin
			halt_on_error(ERR_MAX);
		end else begin
			rx_hdr_count = 4'd0;
			if (rx_masked) begin
				rx_key   = 32'd0;
				rx_phase = PH_KEY;
			end else begin
				open_payload();
			end
		end
	endfunction

	function automatic void track_stream_byte(input logic [7:0] b);
		logic [7:0] plain;
		if (rx_halted)
			return;
		case (rx_phase)
			PH_HDR1: begin
				rx_masked    = b[7];
				rx_hdr_count = 4'd0;
				rx_length    = 64'd0;
				if (b[6:0] == LEN7_EXT16) begin
					rx_phase = PH_EXT16;
				end else if (b[6:0] == LEN7_EXT64) begin
					rx_phase = PH_EXT64;
				end else begin
					rx_length = {57'd0, b[6:0]};
					close_length();
				end
			end
			PH_EXT16: begin
				rx_length    = {48'd0, rx_length[7:0], b};
				rx_hdr_count = rx_hdr_count + 4'd1;
				if (rx_hdr_count == 4'd2) begin
					if (rx_length < 64'd126)
						halt_on_error(ERR_LEN16);
					else
						close_length();
				end
			end
			PH_EXT64: begin
				rx_length    = {rx_length[55:0], b};
				rx_hdr_count = rx_hdr_count + 4'd1;
				if (rx_hdr_count == 4'd8) begin
					if (rx_length <= 64'hFFFF || rx_length[63])
						halt_on_error(ERR_LEN64);
					else
						close_length();
				end
			end
			PH_KEY: begin
				rx_key       = {rx_key[23:0], b};
				rx_hdr_count = rx_hdr_count + 4'd1;
				if (rx_hdr_count == 4'd4) begin
					rx_hdr_count = 4'd0;
					open_payload();
				end
			end
			PH_PAYLOAD: begin
				// first key byte sits in the top bits
				plain = rx_masked ? b ^ rx_key[8 * (3 - int'(rx_key_pos)) +: 8] : b;
				rx_key_pos = rx_key_pos + 2'd1;
				rx_left    = rx_left - 64'd1;
				if (rx_left == 64'd0)
					rx_phase = PH_HDR0;
				owe_result(KIND_PAYLOAD, plain, rx_left == 64'd0, ERR_NONE);
			end
			default: begin
				rx_fin_opcode = {b[7], b[3:0]};
				rx_phase      = PH_HDR1;
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- result side

	function automatic string describe(input decoded_result_t r);
		return $sformatf("kind %0d byte %02h opcode %h fin %b last %b err %0d",
			r.kind, r.data, r.opcode, r.fin, r.last, r.err);
	endfunction

	// ready drops for a random wait after each result, or for a long hold-off
	initial begin : result_receiver
		int wait_left;
		m_axis_tready = 1'b0;
		wait_left     = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				wait_left = $urandom_range(0, recv_gap_max);
			@(negedge clk);
			if (stall_cycles_left > 0) begin
				stall_cycles_left--;
				m_axis_tready <= 1'b0;
			end else if (wait_left > 0) begin
				wait_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		decoded_result_t got;
		decoded_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind   = m_axis_tuser;
			got.data   = m_axis_tdata[7:0];
			got.opcode = m_axis_tdata[11:8];
			got.fin    = m_axis_tdata[12];
			got.err    = m_axis_tdata[14:13];
			got.last   = m_axis_tlast;
			results_checked++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing owed: %s", $realtime, describe(got));
			end else begin
				want = expected_results.pop_front();
				if (got !== want || m_axis_tdata[15] !== 1'b0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch, expected %s, got %s (tdata %04h)",
							$realtime, describe(want), describe(got), m_axis_tdata);
				end
			end
		end
	end

	// cycle budget; also counts cycles in which the input was held off
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
			if (arst_n && s_axis_tvalid && !s_axis_tready)
				input_stall_cycles++;
		end
		$display("run stopped at the cycle limit with %0d results owed",
			expected_results.size());
		$display("*** FAILED ***");
		$finish;
	end

	// ---------------------------------------------------------------- request side

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_byte(input logic [7:0] value);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  <= value;
		s_axis_tvalid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		track_stream_byte(value);
		bytes_accepted++;
		@(negedge clk);
	endtask

	// shortest length form, key only when masked, random payload
	task automatic send_frame(input logic [7:0] hdr, input logic masked_frame,
			input logic [63:0] payload_len, input logic [31:0] frame_key);
		send_byte(hdr);
		if (payload_len <= 64'd125) begin
			send_byte({masked_frame, payload_len[6:0]});
		end else if (payload_len <= 64'hFFFF) begin
			send_byte({masked_frame, LEN7_EXT16});
			send_byte(payload_len[15:8]);
			send_byte(payload_len[7:0]);
		end else begin
			send_byte({masked_frame, LEN7_EXT64});
			for (int i = 7; i >= 0; i--)
				send_byte(payload_len[8 * i +: 8]);
		end
		if (masked_frame)
			for (int i = 3; i >= 0; i--)
				send_byte(frame_key[8 * i +: 8]);
		for (longint unsigned n = 0; n < payload_len; n++)
			send_byte(8'($urandom));
		frames_sent++;
		if (payload_len == 64'd0)
			empty_frames++;
		else if (payload_len > 64'hFFFF)
			ext64_frames++;
		else if (payload_len > 64'd125)
			ext16_frames++;
	endtask

	// header bytes give no result, so allow the pipeline to settle too
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (2 * DUT_LATENCY) @(negedge clk);
	endtask

	task automatic write_max_length(input logic [MAX_LEN_W-1:0] value);
		drain_results();
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we        <= 1'b0;
		rx_max_length  = value;
		config_writes++;
	endtask

	// ---------------------------------------------------------------- tests

	// hand-picked frames: all header bits, both mask forms, extreme bytes
	task automatic test_directed_frames();
		// empty unmasked frame, all header bits clear
		send_byte(8'h00);
		send_byte(8'h00);
		// empty masked frame, fin, reserved bits and opcode all set
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'hFF);
		// masked binary frame of two bytes
		send_byte(8'h82);
		send_byte(8'h82);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hA5);
		send_byte(8'h5A);
		send_byte(8'hFF);
		send_byte(8'h00);
		// unmasked frame, payload passes unchanged
		send_byte(8'h71);
		send_byte(8'h03);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
	endtask

	// limit at both extremes and frames exactly at the limit
	task automatic test_length_boundaries();
		logic [MAX_LEN_W-1:0] bound;
		write_max_length('0);
		repeat (4) send_frame(8'($urandom), 1'($urandom), 64'd0, $urandom);
		write_max_length(MAX_LEN_ALL);
		send_frame(8'($urandom), 1'b1, 64'd125, $urandom);
		send_frame(8'($urandom), 1'b0, 64'd126, $urandom);
		bound = MAX_LEN_W'($urandom_range(126, 200));
		write_max_length(bound);
		send_frame(8'($urandom), 1'($urandom), {1'b0, bound}, $urandom);
		bound = MAX_LEN_W'($urandom_range(1, 125));
		write_max_length(bound);
		send_frame(8'($urandom), 1'($urandom), {1'b0, bound}, $urandom);
		write_max_length(MAX_LEN_RESET);
	endtask

	// bursts of well-formed frames under changing limits and idle patterns
	task automatic test_random_frames();
		int stop_at;
		int pick;
		logic [63:0] len;
		stop_at = bytes_accepted + 600;
		while (bytes_accepted < stop_at) begin
			case ($urandom_range(0, 4))
				0: write_max_length(MAX_LEN_ALL);
				1: write_max_length(MAX_LEN_RESET);
				2: write_max_length(MAX_LEN_W'({$urandom, $urandom}));
				3: write_max_length(MAX_LEN_W'($urandom_range(0, 300)));
				default: drain_results();
			endcase
			send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
			recv_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
			repeat ($urandom_range(3, 10)) begin
				pick = $urandom_range(0, 99);
				if (pick < 12)
					len = 64'd0;
				else if (pick < 65)
					len = 64'($urandom_range(1, 8));
				else if (pick < 88)
					len = 64'($urandom_range(9, 125));
				else
					len = 64'($urandom_range(126, 260));
				if (len > {1'b0, rx_max_length})
					len = {1'b0, rx_max_length};
				send_frame(8'($urandom), 1'($urandom), len, $urandom);
			end
		end
		send_gap_max = 9;
		recv_gap_max = 9;
	endtask

	// receiver stalls long while the sender keeps pushing, so the input backs up
	task automatic test_backpressure();
		drain_results();
		send_gap_max      = 0;
		stall_cycles_left = 60;
		send_frame(8'h82, 1'($urandom), 64'd40, $urandom);
		send_gap_max = 9;
		drain_results();
	endtask

	// errors are sticky, so one error kind closes the run, then the block must stay silent
	task automatic test_sticky_error();
		logic [1:0] code;
		logic [7:0] limit;
		case ($urandom_range(0, 2))
			0: code = ERR_LEN16;
			1: code = ERR_LEN64;
			default: code = ERR_MAX;
		endcase
		case (code)
			ERR_LEN16: begin
				// 16-bit length that would have fit in 7 bits
				send_byte(8'($urandom));
				send_byte({1'($urandom), LEN7_EXT16});
				send_byte(8'h00);
				send_byte(8'($urandom_range(0, 125)));
			end
			ERR_LEN64: begin
				send_byte(8'($urandom));
				send_byte({1'($urandom), LEN7_EXT64});
				if ($urandom_range(0, 1) == 1) begin
					// top bit of the 64-bit length set
					send_byte(8'h80 | 8'($urandom));
					repeat (7) send_byte(8'($urandom));
				end else begin
					// 64-bit length that would have fit in 16 bits
					repeat (6) send_byte(8'h00);
					repeat (2) send_byte(8'($urandom));
				end
			end
			default: begin
				limit = 8'($urandom_range(0, 124));
				write_max_length(MAX_LEN_W'(limit));
				send_byte(8'($urandom));
				if ($urandom_range(0, 1) == 1) begin
					send_byte({1'($urandom), 7'($urandom_range(int'(limit) + 1, 125))});
				end else begin
					// well-formed 64-bit length, far above the limit
					send_byte({1'($urandom), LEN7_EXT64});
					repeat (5) send_byte(8'h00);
					send_byte(8'($urandom_range(1, 255)));
					repeat (2) send_byte(8'($urandom));
				end
			end
		endcase
		// everything after the error is swallowed
		repeat (12) send_byte(8'($urandom));
		closing_error = code;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin : stimulus
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		arst_n        = 1'b0;

		rx_phase      = PH_HDR0;
		rx_hdr_count  = 4'd0;
		rx_fin_opcode = 5'd0;
		rx_masked     = 1'b0;
		rx_length     = 64'd0;
		rx_key        = 32'd0;
		rx_left       = 64'd0;
		rx_key_pos    = 2'd0;
		rx_halted     = 1'b0;
		rx_max_length = MAX_LEN_RESET;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_frames();
		test_length_boundaries();
		test_random_frames();
		test_backpressure();
		test_sticky_error();
		drain_results();

		if (expected_results.size() != 0)
			$display("%0d results never arrived", expected_results.size());
		$display("covered %0d frames (%0d empty, %0d with 16-bit, %0d with 64-bit lengths)",
			frames_sent, empty_frames, ext16_frames, ext64_frames);
		$display("in %0d bytes, %0d limit writes, %0d results checked, input held off %0d cycles",
			bytes_accepted, config_writes, results_checked, input_stall_cycles);
		$display("closed by length error %0d", closing_error);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/wsfd_pkg.sv
sv/wsfd_front.sv
sv/wsfd_queue.sv
sv/wsfd_back.sv
sv/websocket_frame_decoder.sv
sv/wsfd_checker.sv
bench/tb.sv
